// ----- hw/rtl/ssvd_pkg.sv -----
// Shared types, constants and segment encoding for the seven-segment shift driver.
`default_nettype none

package ssvd_pkg;

  typedef enum logic [1:0] {
    ActShow  = 2'd0,
    ActClear = 2'd1,
    ActIdle  = 2'd2,
    ActNone  = 2'd3
  } action_e;

  localparam int unsigned NumBits   = 24;
  localparam int unsigned IdxW      = 5;
  localparam int unsigned MagW      = 18;
  localparam int unsigned NumDigits = 6;
  localparam int unsigned BcdW      = 4 * NumDigits;
  localparam int unsigned ConvSteps = MagW;
  localparam int unsigned CntW      = 5;

  localparam logic [7:0] MinusSeg     = 8'h80;
  localparam logic [7:0] DotSeg       = 8'h01;
  localparam logic [7:0] PlainOne     = 8'h42;
  localparam logic [7:0] OneWithMinus = 8'hC2;

  localparam logic [23:0] ClearPattern = 24'h010101;
  localparam logic [23:0] IdlePattern  = 24'hE6EC42;

  localparam logic [MagW-1:0] SmallLimit = 18'd1000;
  localparam logic [MagW-1:0] MidLimit   = 18'd10000;
  localparam logic [MagW-1:0] LargeLimit = 18'd100000;

  // Controller to datapath commands.
  typedef struct packed {
    logic capture;
    logic conv_step;
    logic load;
    logic shift;
  } cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic conv_last;
    logic bit_last;
  } sts_t;

  function automatic logic [7:0] seg_of(input logic [3:0] digit, input logic dot);
    logic [7:0] s;
    unique case (digit)
      4'd0:    s = 8'h7E;
      4'd1:    s = 8'h42;
      4'd2:    s = 8'hEC;
      4'd3:    s = 8'hE6;
      4'd4:    s = 8'hD2;
      4'd5:    s = 8'hB6;
      4'd6:    s = 8'hBE;
      4'd7:    s = 8'h72;
      4'd8:    s = 8'hFE;
      4'd9:    s = 8'hF6;
      default: s = 8'h00;
    endcase
    return dot ? (s | DotSeg) : s;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/ssvd_if.sv -----
// Valid/ready channel interfaces for the request and the serial bit stream.
`default_nettype none

interface ssvd_in_if;
  logic                valid;
  logic                ready;
  logic [1:0]          action;
  logic signed [17:0]  value_hundredths;

  modport source (output valid, output action, output value_hundredths, input ready);
  modport sink   (input valid, input action, input value_hundredths, output ready);
endinterface

interface ssvd_out_if;
  logic valid;
  logic ready;
  logic serial_bit;
  logic latch_strobe;

  modport source (output valid, output serial_bit, output latch_strobe, input ready);
  modport sink   (input valid, input serial_bit, input latch_strobe, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/ssvd_ctrl.sv -----
// Sequencing state machine: capture, binary to BCD conversion, pattern load, serial send.
`default_nettype none

module ssvd_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  input  wire logic [1:0]    in_action_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output ssvd_pkg::cmd_t     cmd_o,
  input  wire ssvd_pkg::sts_t sts_i
);

  typedef enum logic [1:0] {
    StIdle,
    StConv,
    StLoad,
    StSend
  } state_e;

  state_e state_q, state_d;
  logic   in_fire;

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = (state_q == StSend);
  assign in_fire     = in_valid_i && in_ready_o;

  always_comb begin
    state_d           = state_q;
    cmd_o             = '0;
    cmd_o.capture     = in_fire;
    unique case (state_q)
      StIdle: begin
        if (in_fire) begin
          unique case (ssvd_pkg::action_e'(in_action_i))
            ssvd_pkg::ActShow:                     state_d = StConv;
            ssvd_pkg::ActClear, ssvd_pkg::ActIdle: state_d = StLoad;
            default:                               state_d = StIdle;
          endcase
        end
      end
      StConv: begin
        cmd_o.conv_step = 1'b1;
        if (sts_i.conv_last) state_d = StLoad;
      end
      StLoad: begin
        cmd_o.load = 1'b1;
        state_d    = StSend;
      end
      StSend: begin
        cmd_o.shift = out_ready_i;
        if (out_ready_i && sts_i.bit_last) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/ssvd_dp.sv -----
// Datapath: magnitude, shift-and-add-3 BCD converter, segment formatting and shift pattern.
`default_nettype none

module ssvd_dp (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic [1:0]          in_action_i,
  input  wire logic signed [17:0]  in_value_i,
  input  wire ssvd_pkg::cmd_t      cmd_i,
  output ssvd_pkg::sts_t           sts_o,
  output logic                     serial_bit_o,
  output logic                     latch_strobe_o
);

  localparam int unsigned MagW = ssvd_pkg::MagW;
  localparam int unsigned BcdW = ssvd_pkg::BcdW;
  localparam int unsigned CntW = ssvd_pkg::CntW;
  localparam int unsigned IdxW = ssvd_pkg::IdxW;

  // Payload registers of the item in flight.
  logic [1:0]      action_q;
  logic            neg_q;
  logic [MagW-1:0] mag_q;
  logic [MagW-1:0] bin_q, bin_d;
  logic [BcdW-1:0] bcd_q, bcd_d;
  logic [CntW-1:0] cnt_q;

  // Control state.
  logic [23:0]     pattern_q, pattern_d;
  logic [IdxW-1:0] idx_q;

  logic [MagW-1:0] mag_in;
  logic [BcdW-1:0] bcd_adj;

  assign mag_in = in_value_i[MagW-1] ? (~in_value_i + 18'd1) : in_value_i;

  // One shift-and-add-3 step: correct each digit, then shift in the next binary bit.
  always_comb begin
    for (int i = 0; i < ssvd_pkg::NumDigits; i++) begin
      bcd_adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ? (bcd_q[4*i +: 4] + 4'd3)
                                                    : bcd_q[4*i +: 4];
    end
    bcd_d = {bcd_adj[BcdW-2:0], bin_q[MagW-1]};
    bin_d = {bin_q[MagW-2:0], 1'b0};
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      action_q <= in_action_i;
      neg_q    <= in_value_i[MagW-1];
      mag_q    <= mag_in;
      bin_q    <= mag_in;
      bcd_q    <= '0;
      cnt_q    <= '0;
    end else if (cmd_i.conv_step) begin
      bin_q <= bin_d;
      bcd_q <= bcd_d;
      cnt_q <= cnt_q + CntW'(1);
    end
  end

  // Segment formatting from the decimal digits; d0 is the hundredths digit.
  always_comb begin
    logic [3:0] d0, d1, d2, d3, d4;
    logic [7:0] left, mid, right;
    d0    = bcd_q[3:0];
    d1    = bcd_q[7:4];
    d2    = bcd_q[11:8];
    d3    = bcd_q[15:12];
    d4    = bcd_q[19:16];
    left  = 8'h00;
    mid   = 8'h00;
    right = 8'h00;
    if (mag_q != '0 && mag_q < ssvd_pkg::SmallLimit) begin
      left  = ssvd_pkg::seg_of(d2, 1'b1);
      mid   = ssvd_pkg::seg_of(d1, 1'b0);
      right = ssvd_pkg::seg_of(d0, 1'b0);
    end else if (mag_q >= ssvd_pkg::SmallLimit && mag_q < ssvd_pkg::MidLimit) begin
      left  = ssvd_pkg::seg_of(d3, 1'b0);
      mid   = ssvd_pkg::seg_of(d2, 1'b1);
      right = ssvd_pkg::seg_of(d1, 1'b0);
    end else if (mag_q >= ssvd_pkg::MidLimit && mag_q < ssvd_pkg::LargeLimit) begin
      left  = ssvd_pkg::seg_of(d4, 1'b0);
      mid   = ssvd_pkg::seg_of(d3, 1'b0);
      right = ssvd_pkg::seg_of(d2, 1'b1);
    end
    if (neg_q) begin
      if (left == ssvd_pkg::PlainOne) begin
        left = ssvd_pkg::OneWithMinus;
      end else begin
        right = mid;
        mid   = left;
        left  = ssvd_pkg::MinusSeg;
      end
    end
    unique case (ssvd_pkg::action_e'(action_q))
      ssvd_pkg::ActShow:  pattern_d = {right, mid, left};
      ssvd_pkg::ActClear: pattern_d = ssvd_pkg::ClearPattern;
      ssvd_pkg::ActIdle:  pattern_d = ssvd_pkg::IdlePattern;
      default:            pattern_d = pattern_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_q <= '0;
      idx_q     <= '0;
    end else begin
      if (cmd_i.load) begin
        pattern_q <= pattern_d;
        idx_q     <= '0;
      end else if (cmd_i.shift) begin
        idx_q <= sts_o.bit_last ? '0 : idx_q + IdxW'(1);
      end
    end
  end

  assign sts_o.conv_last = (cnt_q == CntW'(ssvd_pkg::ConvSteps - 1));
  assign sts_o.bit_last  = (idx_q == IdxW'(ssvd_pkg::NumBits - 1));
  assign serial_bit_o    = pattern_q[idx_q];
  assign latch_strobe_o  = sts_o.bit_last;

endmodule

`default_nettype wire

// ----- hw/rtl/seven_segment_value_shift_driver.sv -----
// Top level of the seven-segment value shift driver.
//
//   channel  dir  payload                          accepted when
//   in_i     in   action, value_hundredths         in_i.valid && in_i.ready
//   out_o    out  serial_bit, latch_strobe         out_o.valid && out_o.ready
//
// A show request is captured, passes through the shift-and-add-3 BCD converter
// (one magnitude bit each step), has its pattern loaded and then sends its 24
// bits. Clear and idle requests skip the converter; action 3 is taken with no
// bits sent. A stall on out_o holds the current bit; a new item is taken only
// after the bit carrying latch_strobe has gone. Reset clears the pattern to
// blanks.
`default_nettype none

module seven_segment_value_shift_driver (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  ssvd_in_if.sink         in_i,
  ssvd_out_if.source      out_o
);

  ssvd_pkg::cmd_t cmd;
  ssvd_pkg::sts_t sts;

  ssvd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_action_i (in_i.action),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  ssvd_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_action_i    (in_i.action),
    .in_value_i     (in_i.value_hundredths),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .serial_bit_o   (out_o.serial_bit),
    .latch_strobe_o (out_o.latch_strobe)
  );

endmodule

`default_nettype wire

// ----- hw/rtl/ssvd_checker.sv -----
// Port-level checker for the seven-segment shift driver and its bind.
`default_nettype none

module ssvd_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_ready_i,
  input wire logic [1:0] in_action_i,
  input wire logic       out_valid_i,
  input wire logic       out_ready_i,
  input wire logic       serial_bit_i,
  input wire logic       latch_strobe_i
);

  // The block never takes a request while bits of an earlier one are pending.
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !in_ready_i)
    else $error("input ready while a bit is pending");

  // After a request that has bits to send is taken, the block is busy in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i && (in_action_i != ssvd_pkg::ActNone)) |=> !in_ready_i)
    else $error("input ready right after an accepted item");

  // The item ends with the latch bit: the stream stops right after it.
  a_latch_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && out_ready_i && latch_strobe_i) |=> !out_valid_i)
    else $error("bit stream continued after the latch bit");

  // A stalled bit holds.
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable(serial_bit_i) && $stable(latch_strobe_i)))
    else $error("stalled output changed");

endmodule

bind seven_segment_value_shift_driver ssvd_checker u_ssvd_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .in_action_i    (in_i.action),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .serial_bit_i   (out_o.serial_bit),
  .latch_strobe_i (out_o.latch_strobe)
);

`default_nettype wire

// ----- bench/tb_seven_segment_value_shift_driver.sv -----
// Self-checking testbench for the seven-segment value shift driver.
`timescale 1ns / 1ps

module tb_seven_segment_value_shift_driver;

  typedef struct {
    ssvd_pkg::action_e  act;
    logic signed [17:0] value;
    bit                 known;
    logic [23:0]        pattern;
  } stim_row_t;

  typedef struct {
    bit serial;
    bit latch;
    int item_no;
    int bit_no;
  } bit_expect_t;

  localparam logic [7:0] DIGIT_SEGS [10] = '{
    8'h7E, 8'h42, 8'hEC, 8'hE6, 8'hD2, 8'hB6, 8'hBE, 8'h72, 8'hFE, 8'hF6
  };

  // Known patterns are typed in only where they follow from the encoding at once.
  localparam int NumRows = 25;
  stim_row_t directed_rows [NumRows] = '{
    '{ssvd_pkg::ActClear, 18'sd0,       1'b1, 24'h010101},
    '{ssvd_pkg::ActIdle,  18'sd0,       1'b1, 24'hE6EC42},
    '{ssvd_pkg::ActShow,  18'sd0,       1'b1, 24'h000000},
    '{ssvd_pkg::ActShow,  18'sd131071,  1'b1, 24'h000000},
    '{ssvd_pkg::ActShow,  -18'sd131072, 1'b1, 24'h000080},
    '{ssvd_pkg::ActShow,  18'sd100000,  1'b1, 24'h000000},
    '{ssvd_pkg::ActShow,  -18'sd100000, 1'b1, 24'h000080},
    '{ssvd_pkg::ActShow,  18'sd1,       1'b0, 24'h0},
    '{ssvd_pkg::ActShow,  -18'sd1,      1'b0, 24'h0},
    '{ssvd_pkg::ActShow,  18'sd999,     1'b0, 24'h0},
    '{ssvd_pkg::ActShow,  18'sd1000,    1'b0, 24'h0},
    '{ssvd_pkg::ActShow,  18'sd9999,    1'b0, 24'h0},
    '{ssvd_pkg::ActShow,  18'sd10000,   1'b0, 24'h0},
    '{ssvd_pkg::ActShow,  18'sd99999,   1'b0, 24'h0},
    '{ssvd_pkg::ActShow,  -18'sd99999,  1'b0, 24'h0},
    '{ssvd_pkg::ActShow,  -18'sd1000,   1'b0, 24'h0},
    '{ssvd_pkg::ActShow,  -18'sd10000,  1'b0, 24'h0},
    '{ssvd_pkg::ActShow,  -18'sd100,    1'b0, 24'h0},
    '{ssvd_pkg::ActNone,  18'sd12345,   1'b0, 24'h0},
    '{ssvd_pkg::ActShow,  18'sd12345,   1'b0, 24'h0},
    '{ssvd_pkg::ActShow,  -18'sd5678,   1'b0, 24'h0},
    '{ssvd_pkg::ActShow,  18'sd87381,   1'b0, 24'h0},
    '{ssvd_pkg::ActShow,  -18'sd87382,  1'b0, 24'h0},
    '{ssvd_pkg::ActNone,  -18'sd1,      1'b0, 24'h0},
    '{ssvd_pkg::ActClear, -18'sd1,      1'b0, 24'h0}
  };

  logic clk_i = 1'b0;
  logic rst_ni;

  ssvd_in_if  in_if ();
  ssvd_out_if out_if ();

  seven_segment_value_shift_driver dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  bit_expect_t expected_bits_q [$];
  int          error_count;
  int          items_taken;
  int unsigned src_idle_pct;
  int unsigned snk_idle_pct;

  always #5 clk_i = ~clk_i;

  function automatic logic [7:0] digit_seg(int unsigned d, bit dot);
    logic [7:0] s;
    s = DIGIT_SEGS[d % 10];
    return dot ? (s | 8'h01) : s;
  endfunction

  // Segment pattern for one request: left byte in bits 7..0, right byte in 23..16.
  function automatic logic [23:0] display_pattern(ssvd_pkg::action_e act,
                                                  logic signed [17:0] v);
    logic        neg;
    logic [17:0] mag18;
    int unsigned m;
    logic [7:0]  lft, mid, rgt;
    lft = 8'h00;
    mid = 8'h00;
    rgt = 8'h00;
    if (act == ssvd_pkg::ActClear) return 24'h010101;
    if (act == ssvd_pkg::ActIdle) return 24'hE6EC42;
    neg = v[17];
    // Negating the most negative input wraps to 2^17, which lands out of range.
    mag18 = neg ? (18'd0 - v) : v;
    m = neg && (mag18 == 18'd0) ? 32'h20000 : mag18;
    if (m > 0 && m < 1000) begin
      lft = digit_seg(m / 100, 1'b1);
      mid = digit_seg((m / 10) % 10, 1'b0);
      rgt = digit_seg(m % 10, 1'b0);
    end else if (m >= 1000 && m < 10000) begin
      lft = digit_seg(m / 1000, 1'b0);
      mid = digit_seg((m / 100) % 10, 1'b1);
      rgt = digit_seg((m / 10) % 10, 1'b0);
    end else if (m >= 10000 && m < 100000) begin
      lft = digit_seg(m / 10000, 1'b0);
      mid = digit_seg((m / 1000) % 10, 1'b0);
      rgt = digit_seg((m / 100) % 10, 1'b1);
    end
    if (neg) begin
      if (lft == 8'h42) begin
        lft = 8'hC2;
      end else begin
        rgt = mid;
        mid = lft;
        lft = 8'h80;
      end
    end
    return {rgt, mid, lft};
  endfunction

  task automatic report_mismatch(input string msg);
    error_count++;
    $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  task automatic drive_item(input ssvd_pkg::action_e act, input logic signed [17:0] v,
                            input bit known, input logic [23:0] known_pattern);
    logic [23:0] pattern;
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_if.valid = 1'b0;
      in_if.action = 2'($urandom_range(0, 3));
      in_if.value_hundredths = 18'($urandom);
      @(negedge clk_i);
    end
    in_if.valid = 1'b1;
    in_if.action = act;
    in_if.value_hundredths = v;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    items_taken++;
    if (act != ssvd_pkg::ActNone) begin
      pattern = known ? known_pattern : display_pattern(act, v);
      for (int i = 0; i < ssvd_pkg::NumBits; i++)
        expected_bits_q.push_back('{pattern[i], i == ssvd_pkg::NumBits - 1,
                                    items_taken, i});
    end
    @(negedge clk_i);
  endtask

  task automatic drain_and_set_idle(input int unsigned src_pct, input int unsigned snk_pct);
    in_if.valid = 1'b0;
    while (expected_bits_q.size() != 0) @(negedge clk_i);
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
  endtask

  task automatic drive_random_item();
    ssvd_pkg::action_e  act;
    int unsigned        pick;
    int unsigned        mag;
    logic signed [17:0] v;
    pick = $urandom_range(0, 99);
    if (pick < 75) act = ssvd_pkg::ActShow;
    else if (pick < 85) act = ssvd_pkg::ActClear;
    else if (pick < 95) act = ssvd_pkg::ActIdle;
    else act = ssvd_pkg::ActNone;
    case ($urandom_range(0, 9))
      0, 1:    mag = $urandom_range(1, 999);
      2, 3:    mag = $urandom_range(1000, 9999);
      4, 5:    mag = $urandom_range(10000, 99999);
      6:       mag = $urandom_range(100000, 131071);
      7:       mag = 0;
      default: mag = $urandom_range(0, 131071);
    endcase
    v = 18'(mag);
    if ($urandom_range(0, 1)) v = -v;
    drive_item(act, v, 1'b0, 24'h0);
  endtask

  // The receiver decides its ready for the coming edge at each falling edge.
  always @(negedge clk_i) begin
    out_if.ready = ($urandom_range(0, 99) >= snk_idle_pct);
  end

  always @(posedge clk_i) begin
    bit_expect_t e;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (expected_bits_q.size() == 0) begin
        report_mismatch($sformatf("bit %0b latch %0b with nothing pending",
                                  out_if.serial_bit, out_if.latch_strobe));
      end else begin
        e = expected_bits_q.pop_front();
        if (out_if.serial_bit !== e.serial)
          report_mismatch($sformatf("item %0d bit %0d: serial %0b, want %0b",
                                    e.item_no, e.bit_no, out_if.serial_bit, e.serial));
        if (out_if.latch_strobe !== e.latch)
          report_mismatch($sformatf("item %0d bit %0d: latch %0b, want %0b",
                                    e.item_no, e.bit_no, out_if.latch_strobe, e.latch));
      end
    end
  end

  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin
    rst_ni = 1'b0;
    error_count = 0;
    items_taken = 0;
    src_idle_pct = 34;
    snk_idle_pct = 88;
    in_if.valid = 1'b0;
    in_if.action = ssvd_pkg::ActShow;
    in_if.value_hundredths = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[r])
      drive_item(directed_rows[r].act, directed_rows[r].value,
                 directed_rows[r].known, directed_rows[r].pattern);

    for (int n = 0; n < 25; n++) drive_random_item();
    // The sender holds off here until the stream has fully drained.
    drain_and_set_idle(88, 34);
    for (int n = 0; n < 25; n++) drive_random_item();
    drain_and_set_idle(0, 0);
    for (int n = 0; n < 25; n++) drive_random_item();

    in_if.valid = 1'b0;
    while (expected_bits_q.size() != 0) @(negedge clk_i);
    repeat (60) @(posedge clk_i);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/ssvd_pkg.sv
hw/rtl/ssvd_if.sv
hw/rtl/ssvd_ctrl.sv
hw/rtl/ssvd_dp.sv
hw/rtl/seven_segment_value_shift_driver.sv
hw/rtl/ssvd_checker.sv
bench/tb_seven_segment_value_shift_driver.sv
